// ===== rtl/core/vsc_pkg.sv =====
package vsc_pkg;

	// Key storage geometry
	localparam int unsigned MAX_KEY_LETTERS = 20;
	localparam int unsigned KEY_BITS        = 6;
	localparam int unsigned KEY_REG_LETTERS = MAX_KEY_LETTERS / 2;
	localparam int unsigned KEY_REG_W       = KEY_BITS * KEY_REG_LETTERS;
	localparam int unsigned KEY_LEN_W       = 5;
	localparam int unsigned CFG_DATA_W      = KEY_REG_W;
	localparam int unsigned CFG_INDEX_W     = 2;

	// Alphabet: 33 letters, index 33 marks a non-letter
	localparam logic [6:0] ALPHA_SIZE = 7'd33;
	localparam logic [5:0] NOT_LETTER = 6'd33;
	localparam logic [5:0] KEY_MAX    = 6'd32;
	localparam logic [5:0] IO_INDEX   = 6'd6;

	// Windows-1251 code points used by the case folding and letter map
	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] CYR_UPPER_A   = 8'hC0;
	localparam logic [7:0] CYR_UPPER_YA  = 8'hDF;
	localparam logic [7:0] CYR_UPPER_IO  = 8'hA8;
	localparam logic [7:0] CYR_LOWER_IO  = 8'hB8;
	localparam logic [7:0] CYR_LOWER_A   = 8'hE0;
	localparam logic [7:0] CYR_LOWER_IE  = 8'hE5;
	localparam logic [7:0] CYR_LOWER_ZH  = 8'hE6;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KEY_LOW      = 2'd0,
		REG_KEY_HIGH     = 2'd1,
		REG_KEY_LENGTH   = 2'd2,
		REG_ENCRYPT_MODE = 2'd3
	} cfg_reg_t;

	// Key setup handed to the cipher datapath
	typedef struct packed {
		logic [KEY_REG_W-1:0] letters_high;
		logic [KEY_REG_W-1:0] letters_low;
		logic [KEY_LEN_W-1:0] length;
		logic                 encrypt;
	} key_cfg_t;

	// Fold A-Z, capital Cyrillic and capital IO to lower case
	function automatic logic [7:0] lower_byte(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if ((b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ||
		    (b >= CYR_UPPER_A && b <= CYR_UPPER_YA))
			r = b + CASE_OFFSET;
		else if (b == CYR_UPPER_IO)
			r = CYR_LOWER_IO;
		return r;
	endfunction

	// Lower-case letter to alphabet index, NOT_LETTER otherwise
	function automatic logic [5:0] letter_index(input logic [7:0] b);
		logic [7:0] d;
		logic [5:0] r;
		d = b - CYR_LOWER_A;
		r = NOT_LETTER;
		if (b >= CYR_LOWER_A && b <= CYR_LOWER_IE)
			r = d[5:0];
		else if (b == CYR_LOWER_IO)
			r = IO_INDEX;
		else if (b >= CYR_LOWER_ZH)
			r = d[5:0] + 6'd1;
		return r;
	endfunction

	// Alphabet index back to its byte
	function automatic logic [7:0] index_byte(input logic [5:0] idx);
		logic [7:0] r;
		if (idx < IO_INDEX)
			r = CYR_LOWER_A + {2'b00, idx};
		else if (idx == IO_INDEX)
			r = CYR_LOWER_IO;
		else
			r = CYR_LOWER_A + {2'b00, idx} - 8'd1;
		return r;
	endfunction

endpackage

// ===== rtl/core/vsc_if.sv =====
// Plaintext / ciphertext input channel
interface vsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       message_start;
	logic       message_end;

	modport source (output valid, text_byte, message_start, message_end, input ready);
	modport sink   (input valid, text_byte, message_start, message_end, output ready);
endinterface

// Result channel
interface vsc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_end;

	modport source (output valid, out_byte, out_end, input ready);
	modport sink   (input valid, out_byte, out_end, output ready);
endinterface

// ===== rtl/core/vsc_cipher_unit.sv =====
// One byte of the cipher: case folding, key letter pick, mod-33 shift,
// and the key position that the next byte will see.
module vsc_cipher_unit (
	input  vsc_pkg::key_cfg_t               key_cfg,
	input  logic [vsc_pkg::KEY_LEN_W-1:0]   key_pos,
	input  logic [7:0]                      text_byte,
	input  logic                            message_start,
	output logic [7:0]                      res_byte,
	output logic [vsc_pkg::KEY_LEN_W-1:0]   next_pos
);

	localparam logic [vsc_pkg::KEY_LEN_W-1:0] MAX_LEN =
		vsc_pkg::KEY_LEN_W'(vsc_pkg::MAX_KEY_LETTERS);

	logic [vsc_pkg::KEY_BITS-1:0]  letters [vsc_pkg::MAX_KEY_LETTERS];
	logic [vsc_pkg::KEY_LEN_W-1:0] len;
	logic [vsc_pkg::KEY_LEN_W-1:0] pos_cur;
	logic [vsc_pkg::KEY_LEN_W-1:0] pos;
	logic [vsc_pkg::KEY_LEN_W-1:0] pos_inc;
	logic [5:0]                    k_raw;
	logic [5:0]                    k;
	logic [7:0]                    lb;
	logic [5:0]                    t;
	logic                          is_letter;
	logic [6:0]                    sum;
	logic [6:0]                    sum_mod;

	// Unpack the two key registers into letter slots
	for (genvar i = 0; i < vsc_pkg::MAX_KEY_LETTERS; i++) begin : g_slot
		if (i < vsc_pkg::KEY_REG_LETTERS) begin : g_low
			assign letters[i] = key_cfg.letters_low[i*vsc_pkg::KEY_BITS +: vsc_pkg::KEY_BITS];
		end else begin : g_high
			assign letters[i] = key_cfg.letters_high[
				(i-vsc_pkg::KEY_REG_LETTERS)*vsc_pkg::KEY_BITS +: vsc_pkg::KEY_BITS];
		end
	end

	// Key length clamp and position select (stale position falls back to letter 0)
	always_comb begin
		len     = (key_cfg.length > MAX_LEN) ? MAX_LEN : key_cfg.length;
		pos_cur = message_start ? '0 : key_pos;
		pos     = (pos_cur < len) ? pos_cur : '0;
		pos_inc = pos + vsc_pkg::KEY_LEN_W'(1);
		k_raw   = letters[pos];
		k       = (k_raw > vsc_pkg::KEY_MAX) ? vsc_pkg::KEY_MAX : k_raw;
	end

	// Letter map and modulo-33 add or subtract
	always_comb begin
		lb        = vsc_pkg::lower_byte(text_byte);
		t         = vsc_pkg::letter_index(lb);
		is_letter = (t != vsc_pkg::NOT_LETTER);
		if (key_cfg.encrypt)
			sum = {1'b0, t} + {1'b0, k};
		else
			sum = {1'b0, t} + vsc_pkg::ALPHA_SIZE - {1'b0, k};
		sum_mod = (sum >= vsc_pkg::ALPHA_SIZE) ? sum - vsc_pkg::ALPHA_SIZE : sum;
	end

	// Result byte and key position update
	always_comb begin
		res_byte = text_byte;
		next_pos = pos_cur;
		if (len != '0) begin
			res_byte = lb;
			if (is_letter) begin
				res_byte = vsc_pkg::index_byte(sum_mod[5:0]);
				next_pos = (pos_inc >= len) ? '0 : pos_inc;
			end
		end
	end

endmodule

// ===== rtl/core/vigenere_stream_cipher_core.sv =====
// Vigenere stream cipher over the 33-letter Russian alphabet in Windows-1251.
// Each input transaction carries one byte and yields exactly one output byte,
// in order. Latin and Cyrillic capitals are folded to lower case; Cyrillic
// letters are shifted by the current key letter modulo 33 (added when
// encrypt_mode is 1, subtracted when 0), and the key position advances only on
// letters and restarts on message_start. Key length zero passes bytes through
// untouched. Throughput is one byte per clock while the output is not stalled,
// set by the key position register, which updates as each byte leaves the input
// register. An accepted byte passes the input register and then the output
// register; a stalled output holds the input register and then the input.
// Configuration must be written while idle.
module vigenere_stream_cipher_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [vsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	vsc_in_if.sink                            text_in,
	vsc_out_if.source                         text_out
);

	vsc_pkg::key_cfg_t             key_cfg_q;
	logic [vsc_pkg::KEY_LEN_W-1:0] key_pos_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_end_q;

	logic                          advance;
	logic                          in_ready;
	logic [7:0]                    res_byte;
	logic [vsc_pkg::KEY_LEN_W-1:0] next_pos;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cfg_q.letters_low  <= '0;
			key_cfg_q.letters_high <= '0;
			key_cfg_q.length       <= '0;
			key_cfg_q.encrypt      <= 1'b1;
		end else if (cfg_we) begin
			unique case (vsc_pkg::cfg_reg_t'(cfg_index))
				vsc_pkg::REG_KEY_LOW:      key_cfg_q.letters_low  <= cfg_data;
				vsc_pkg::REG_KEY_HIGH:     key_cfg_q.letters_high <= cfg_data;
				vsc_pkg::REG_KEY_LENGTH:   key_cfg_q.length <= cfg_data[vsc_pkg::KEY_LEN_W-1:0];
				vsc_pkg::REG_ENCRYPT_MODE: key_cfg_q.encrypt <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the output register is free or drained
	assign advance       = valid_s1 && (!out_valid_q || text_out.ready);
	assign in_ready      = !valid_s1 || advance;
	assign text_in.ready = in_ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= text_in.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && text_in.valid) begin
			byte_s1  <= text_in.text_byte;
			start_s1 <= text_in.message_start;
			end_s1   <= text_in.message_end;
		end
	end

	vsc_cipher_unit u_cipher (
		.key_cfg       (key_cfg_q),
		.key_pos       (key_pos_q),
		.text_byte     (byte_s1),
		.message_start (start_s1),
		.res_byte      (res_byte),
		.next_pos      (next_pos)
	);

	// Key position advances with each byte leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			key_pos_q <= '0;
		else if (advance)
			key_pos_q <= next_pos;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (text_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= res_byte;
			out_end_q  <= end_s1;
		end
	end

	assign text_out.valid    = out_valid_q;
	assign text_out.out_byte = out_byte_q;
	assign text_out.out_end  = out_end_q;

endmodule

// ===== rtl/core/vsc_checker.sv =====
module vsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_end
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_end))
		else $error("result changed while stalled");

	// Input backpressure only when the output side is stalled with data
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A transaction taken with the output empty passes the input register and then shows up in the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("accepted transaction produced no result");

	// Output is empty while reset is applied
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind vigenere_stream_cipher_core vsc_checker u_vsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text_in.valid),
	.in_ready  (text_in.ready),
	.out_valid (text_out.valid),
	.out_ready (text_out.ready),
	.out_byte  (text_out.out_byte),
	.out_end   (text_out.out_end)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned PHASE_ITEMS  = 600;
	localparam int unsigned PLAN_ROWS    = 31;

	typedef enum logic {ROW_TEXT, ROW_CFG} row_kind_t;

	// One line of the directed plan: either a register write or a text byte
	typedef struct packed {
		row_kind_t                      kind;
		vsc_pkg::cfg_reg_t              cfg_sel;
		logic [vsc_pkg::CFG_DATA_W-1:0] cfg_value;
		logic [7:0]                     text;
		logic                           first;
		logic                           last;
		logic                           typed;
		logic [7:0]                     want;
	} plan_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_end;
	} cipher_out_t;

	// Directed plan; typed results are hand-derived, the rest come from the predictor
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// zero key length: raw pass-through, no case folding
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h41, 1'b1, 1'b0, 1'b1, 8'h41},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hC0, 1'b0, 1'b0, 1'b1, 8'hC0},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hA8, 1'b0, 1'b0, 1'b1, 8'hA8},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF},
		// key letters 1, 32, 63 (saturates to 32)
		'{ROW_CFG, vsc_pkg::REG_KEY_LOW, 60'h3F801, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, vsc_pkg::REG_KEY_LENGTH, 60'd3, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_CFG, vsc_pkg::REG_ENCRYPT_MODE, 60'd1, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE0, 1'b1, 1'b0, 1'b1, 8'hE1},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hC0, 1'b0, 1'b0, 1'b1, 8'hFF},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hDF, 1'b0, 1'b0, 1'b1, 8'hFE},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h41, 1'b0, 1'b0, 1'b1, 8'h61},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hA8, 1'b0, 1'b0, 1'b1, 8'hE6},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hB8, 1'b1, 1'b1, 1'b1, 8'hE6},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h20, 1'b0, 1'b0, 1'b1, 8'h20},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h5A, 1'b0, 1'b0, 1'b1, 8'h7A},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00},
		// decrypt wraps below index zero
		'{ROW_CFG, vsc_pkg::REG_ENCRYPT_MODE, 60'd0, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE0, 1'b1, 1'b0, 1'b1, 8'hFF},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE6, 1'b0, 1'b0, 1'b1, 8'hE7},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hFF, 1'b0, 1'b1, 1'b1, 8'hE0},
		// all-ones upper key, oversized key length
		'{ROW_CFG, vsc_pkg::REG_KEY_HIGH, 60'hFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0,
		  8'h00},
		'{ROW_CFG, vsc_pkg::REG_KEY_LENGTH, 60'd31, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hC5, 1'b1, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE7, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hF0, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hFA, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'h61, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hD0, 1'b0, 1'b0, 1'b0, 8'h00},
		// shrink key under a running position: falls back to letter 0
		'{ROW_CFG, vsc_pkg::REG_KEY_LENGTH, 60'd2, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE3, 1'b0, 1'b0, 1'b1, 8'hE2},
		'{ROW_TEXT, vsc_pkg::REG_KEY_LOW, 60'h0, 8'hE3, 1'b0, 1'b1, 1'b1, 8'hE4}
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [vsc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [vsc_pkg::CFG_DATA_W-1:0]  cfg_data;

	vsc_in_if  text_in_bus ();
	vsc_out_if text_out_bus ();

	vigenere_stream_cipher_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_in   (text_in_bus),
		.text_out  (text_out_bus)
	);

	// Shadow of the key setup and the running key position
	logic [vsc_pkg::CFG_DATA_W-1:0] key_low_sh;
	logic [vsc_pkg::CFG_DATA_W-1:0] key_high_sh;
	logic [vsc_pkg::KEY_LEN_W-1:0]  key_len_sh;
	logic                           encrypt_sh;
	int unsigned                    key_cursor;

	cipher_out_t   cipher_q [$];
	int unsigned   fail_count;
	int unsigned   stall_cycles;
	int unsigned   send_idle_pct;
	int unsigned   recv_idle_pct;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Capitals (Latin, Cyrillic, IO) to lower case; bit 5 is clear in both capital ranges
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if ((c >= vsc_pkg::ASCII_UPPER_A && c <= vsc_pkg::ASCII_UPPER_Z) ||
		    (c >= vsc_pkg::CYR_UPPER_A && c <= vsc_pkg::CYR_UPPER_YA))
			return c | 8'h20;
		if (c == vsc_pkg::CYR_UPPER_IO)
			return vsc_pkg::CYR_LOWER_IO;
		return c;
	endfunction

	// Position in the 33-letter order, -1 for anything else
	function automatic int alpha_slot(input logic [7:0] c);
		if (c == vsc_pkg::CYR_LOWER_IO)
			return 6;
		if (c >= 8'hE0 && c <= 8'hE5)
			return int'(c) - 'hE0;
		if (c >= 8'hE6)
			return int'(c) - 'hE6 + 7;
		return -1;
	endfunction

	function automatic logic [7:0] slot_glyph(input int n);
		if (n < 6)
			return 8'(8'hE0 + n);
		if (n == 6)
			return vsc_pkg::CYR_LOWER_IO;
		return 8'(8'hDF + n);
	endfunction

	function automatic int key_letter_at(input int unsigned pos);
		logic [2*vsc_pkg::CFG_DATA_W-1:0] all_letters;
		logic [5:0]                       k;
		all_letters = {key_high_sh, key_low_sh};
		k = all_letters[pos*6 +: 6];
		return (k > vsc_pkg::KEY_MAX) ? int'(vsc_pkg::KEY_MAX) : int'(k);
	endfunction

	// Predicts one output byte and advances the key position
	function automatic cipher_out_t cipher_byte(input logic [7:0] c, input logic first,
	                                            input logic last);
		cipher_out_t r;
		int unsigned span;
		int unsigned pos;
		int          slot;
		int          k;
		logic [7:0]  lc;
		span = (key_len_sh > vsc_pkg::MAX_KEY_LETTERS) ? vsc_pkg::MAX_KEY_LETTERS : key_len_sh;
		if (first)
			key_cursor = 0;
		r.out_byte = c;
		r.out_end  = last;
		if (span != 0) begin
			lc = fold_case(c);
			slot = alpha_slot(lc);
			r.out_byte = lc;
			if (slot >= 0) begin
				pos = (key_cursor < span) ? key_cursor : 0;
				k = key_letter_at(pos);
				if (encrypt_sh)
					r.out_byte = slot_glyph((slot + k) % 33);
				else
					r.out_byte = slot_glyph((slot + 33 - k) % 33);
				key_cursor = (pos + 1 >= span) ? 0 : pos + 1;
			end
		end
		return r;
	endfunction

	// Register write; the extra edge keeps back-to-back writes from colliding on cfg_we
	task automatic write_cfg(input vsc_pkg::cfg_reg_t sel,
	                         input logic [vsc_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (sel)
			vsc_pkg::REG_KEY_LOW:      key_low_sh = data;
			vsc_pkg::REG_KEY_HIGH:     key_high_sh = data;
			vsc_pkg::REG_KEY_LENGTH:   key_len_sh = data[vsc_pkg::KEY_LEN_W-1:0];
			vsc_pkg::REG_ENCRYPT_MODE: encrypt_sh = data[0];
			default:                   ;
		endcase
	endtask

	// Drive one input transaction and queue its expected result on acceptance
	task automatic send_text(input logic [7:0] c, input logic first, input logic last,
	                         input logic typed, input logic [7:0] want);
		cipher_out_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			text_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		text_in_bus.valid         <= 1'b1;
		text_in_bus.text_byte     <= c;
		text_in_bus.message_start <= first;
		text_in_bus.message_end   <= last;
		do @(posedge clk); while (!text_in_bus.ready);
		r = cipher_byte(c, first, last);
		if (typed)
			r.out_byte = want;
		cipher_q = {cipher_q, r};
	endtask

	// Block goes idle: input dropped, every result back, pipeline flushed
	task automatic settle();
		text_in_bus.valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly letters of both cases, some Latin, some arbitrary bytes
	function automatic logic [7:0] random_text_byte();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return 8'($urandom_range(8'hE0, 8'hFF));
		if (pick < 65)
			return 8'($urandom_range(8'hC0, 8'hDF));
		if (pick < 70)
			return $urandom_range(1) ? vsc_pkg::CYR_UPPER_IO : vsc_pkg::CYR_LOWER_IO;
		if (pick < 80)
			return 8'($urandom_range(vsc_pkg::ASCII_UPPER_A, vsc_pkg::ASCII_UPPER_Z)) |
			       8'($urandom_range(1) << 5);
		return 8'($urandom_range(255));
	endfunction

	// Key letters mostly in range; a fifth are drawn from the full 6-bit range and may be oversized
	function automatic logic [vsc_pkg::CFG_DATA_W-1:0] random_key();
		logic [vsc_pkg::CFG_DATA_W-1:0] k;
		int unsigned                    i;
		for (i = 0; i < vsc_pkg::KEY_REG_LETTERS; i++)
			k[i*6 +: 6] = ($urandom_range(4) == 0) ? 6'($urandom_range(63))
			                                        : 6'($urandom_range(32));
		return k;
	endfunction

	function automatic logic [vsc_pkg::KEY_LEN_W-1:0] random_key_length();
		case ($urandom_range(9))
			0:       return '0;
			1:       return vsc_pkg::KEY_LEN_W'(1);
			2:       return vsc_pkg::KEY_LEN_W'(vsc_pkg::MAX_KEY_LETTERS);
			3:       return '1;
			4:       return vsc_pkg::KEY_LEN_W'($urandom_range(vsc_pkg::MAX_KEY_LETTERS + 1, 31));
			default: return vsc_pkg::KEY_LEN_W'($urandom_range(1, vsc_pkg::MAX_KEY_LETTERS));
		endcase
	endfunction

	// New key setup; a partial update keeps the old position alive
	task automatic retune_key();
		settle();
		if ($urandom_range(1)) begin
			write_cfg(vsc_pkg::REG_KEY_LOW, random_key());
			write_cfg(vsc_pkg::REG_KEY_HIGH, random_key());
		end
		write_cfg(vsc_pkg::REG_KEY_LENGTH, vsc_pkg::CFG_DATA_W'(random_key_length()));
		if ($urandom_range(2) != 0)
			write_cfg(vsc_pkg::REG_ENCRYPT_MODE, vsc_pkg::CFG_DATA_W'($urandom_range(1)));
	endtask

	// Framed messages with random content, plus some with random framing flags
	task automatic run_phase(input int unsigned quota);
		int unsigned sent;
		int unsigned msg_len;
		int unsigned i;
		logic        broken;
		sent = 0;
		while (sent < quota) begin
			retune_key();
			repeat ($urandom_range(2, 8)) begin
				msg_len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
				broken = ($urandom_range(9) == 0);
				for (i = 0; i < msg_len; i++) begin
					if (broken)
						send_text(random_text_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
						          1'b0, 8'h00);
					else
						send_text(random_text_byte(), i == 0, i == msg_len - 1, 1'b0, 8'h00);
				end
				sent += msg_len;
			end
		end
	endtask

	// Receiver: random stalls, stall watch, compare each result transaction
	always @(posedge clk) begin : check_output
		cipher_out_t head;
		text_out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		if ((text_in_bus.valid && text_in_bus.ready) || (text_out_bus.valid && text_out_bus.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (arst_n && text_out_bus.valid && text_out_bus.ready) begin
			if (cipher_q.size() == 0) begin
				$error("unexpected transaction: out_byte %h out_end %b",
				       text_out_bus.out_byte, text_out_bus.out_end);
				fail_count++;
			end else begin
				head = cipher_q.pop_front();
				if (text_out_bus.out_byte !== head.out_byte) begin
					$error("out_byte: expected %h, actual %h", head.out_byte, text_out_bus.out_byte);
					fail_count++;
				end
				if (text_out_bus.out_end !== head.out_end) begin
					$error("out_end: expected %b, actual %b", head.out_end, text_out_bus.out_end);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on a hung handshake
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("vigenere_stream_cipher_core test failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned idx;
		arst_n                    = 1'b1;
		cfg_we                    = 1'b0;
		cfg_index                 = '0;
		cfg_data                  = '0;
		text_in_bus.valid         = 1'b0;
		text_in_bus.text_byte     = '0;
		text_in_bus.message_start = 1'b0;
		text_in_bus.message_end   = 1'b0;
		text_out_bus.ready        = 1'b0;
		key_low_sh                = '0;
		key_high_sh               = '0;
		key_len_sh                = '0;
		encrypt_sh                = 1'b1;
		key_cursor                = 0;
		fail_count                = 0;
		stall_cycles              = 0;
		send_idle_pct             = 23;
		recv_idle_pct             = 75;

		// A real falling edge on reset, so every flop sees it
		#1 arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan
		for (idx = 0; idx < PLAN_ROWS; idx++) begin
			if (PLAN[idx].kind == ROW_CFG) begin
				settle();
				write_cfg(PLAN[idx].cfg_sel, PLAN[idx].cfg_value);
			end else begin
				send_text(PLAN[idx].text, PLAN[idx].first, PLAN[idx].last,
				          PLAN[idx].typed, PLAN[idx].want);
			end
		end

		// Random traffic under three idle patterns
		run_phase(PHASE_ITEMS);
		settle();
		send_idle_pct = 75;
		recv_idle_pct = 23;
		run_phase(PHASE_ITEMS);
		settle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(PHASE_ITEMS);
		settle();

		if (cipher_q.size() != 0) begin
			$error("%0d expected transactions never arrived", cipher_q.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("vigenere_stream_cipher_core test passed");
		else
			$display("vigenere_stream_cipher_core test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/vsc_pkg.sv
rtl/core/vsc_if.sv
rtl/core/vsc_cipher_unit.sv
rtl/core/vigenere_stream_cipher_core.sv
rtl/core/vsc_checker.sv
tb/testbench.sv
